### src/wwgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwgs_pkg
// Shared types, constants and the cell update rule for the wireworld
// generation step.
// ----------------------------------------------------------------------------
package wwgs_pkg;

    localparam int MAX_ROWS  = 32;
    localparam int MAX_COLS  = 32;
    localparam int CFG_W     = 6;
    localparam int DIM_W     = CFG_W + 1;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int POS_W     = 5;
    localparam int CELL_W    = 2;
    localparam int COLUMN_W  = 3 * CELL_W;
    localparam int WINDOW_W  = 2 * COLUMN_W;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 16;
    localparam int APB_W     = 32;
    localparam int ADDR_W    = 3;

    typedef logic [CELL_W-1:0]   t_cell;
    typedef logic [COLUMN_W-1:0] t_column;
    typedef logic [POS_W-1:0]    t_pos;

    localparam t_cell ST_EMPTY  = 2'd0;
    localparam t_cell ST_HEAD   = 2'd1;
    localparam t_cell ST_TAIL   = 2'd2;
    localparam t_cell ST_COPPER = 2'd3;

    // register select is address bit 2
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(32);
    localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(3);

    typedef struct packed {
        t_cell state;
        t_pos  row;
        t_pos  col;
        logic  last;
    } t_result;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] w;
        w = DIM_W'(v);
        if (w < DIM_MIN) begin
            return DIM_MIN;
        end else if (w > maxv) begin
            return maxv;
        end
        return w;
    endfunction

    function automatic logic is_head(input t_cell c);
        return c == ST_HEAD;
    endfunction

    // columns hold top cell in bits 1:0, centre in 3:2, bottom in 5:4
    function automatic t_cell next_of(input t_column left, input t_column mid,
                                      input t_column right);
        logic [3:0] n;
        t_cell      centre;
        t_cell      res;
        centre = mid[3:2];
        n = {3'b0, is_head(left[1:0])}  + {3'b0, is_head(left[3:2])}
          + {3'b0, is_head(left[5:4])}  + {3'b0, is_head(mid[1:0])}
          + {3'b0, is_head(mid[5:4])}   + {3'b0, is_head(right[1:0])}
          + {3'b0, is_head(right[3:2])} + {3'b0, is_head(right[5:4])};
        unique case (centre)
            ST_EMPTY:  res = ST_EMPTY;
            ST_HEAD:   res = ST_TAIL;
            ST_TAIL:   res = ST_COPPER;
            ST_COPPER: res = (n == 4'd1 || n == 4'd2) ? ST_HEAD : ST_COPPER;
        endcase
        return res;
    endfunction

endpackage

### src/wireworld_generation_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wireworld_generation_step
// Streams one wireworld generation in raster order and emits the next one.
// ----------------------------------------------------------------------------
// Cells enter on the s channel, one 2-bit cell per word. Each cell is held in
// an input register and processed from there against two line buffers and
// a two-column window; results leave through an output register on the m
// channel as {col, row, next_state} with tlast on the last word a cell causes.
// Result words are computed from the input register into the output register.
// Throughput is one cell per cycle when nothing stalls. The last cell of a row
// (from the second row on) gives two words, which stalls input until the second
// word is taken into the output register. The last cell of the frame also
// flushes the final row: column 0 is fetched, then one word per column follows,
// with input held off. An output stall holds the output word and backs up into
// the input register, dropping tready once that register is full.
// After reset both dimensions are 32 and the frame starts at row 0, column 0.
// Writing either register on the APB port restarts the frame; write only
// while the block is idle.
// ----------------------------------------------------------------------------
module wireworld_generation_step
    import wwgs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // [1:0] cell_req
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,   // [1:0] next_state, [6:2] row, [11:7] col
    output logic                o_m_tlast,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [APB_W-1:0]    pwdata,
    output logic [APB_W-1:0]    prdata,
    output logic                pready
);

    logic [CFG_W-1:0]  r_rows_cfg;
    logic [CFG_W-1:0]  r_cols_cfg;
    logic              r_in_valid;
    t_cell             r_in_cell;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [WINDOW_W-1:0] r_window;
    t_cell             r_line_above [MAX_COLS];
    t_cell             r_line_two [MAX_COLS];
    logic              r_out_valid;
    t_result           r_out;
    logic              r_b_valid;
    t_result           r_b;
    logic              r_fl_active;
    logic              r_fl_primed;
    logic [COL_W-1:0]  r_fl_k;
    t_column           r_fl_left;
    t_column           r_fl_mid;
    t_pos              r_fl_row;

    logic [DIM_W-1:0]  rows_eff;
    logic [DIM_W-1:0]  cols_eff;
    logic              col_last;
    logic              row_last;
    logic [COL_W-1:0]  rd_idx;
    t_cell             rd_above;
    t_cell             rd_two;
    t_cell             top;
    t_cell             mid;
    t_column           newcol;
    t_column           prev;
    t_column           oldest;
    logic              has_a;
    logic              has_b;
    logic              do_flush;
    t_result           res_a;
    t_result           res_b;
    t_result           res_fl;
    logic              rc_valid;
    t_column           rc;
    logic              out_free;
    logic              fl_emit;
    logic              proc;
    logic              in_acc;
    logic              cfg_wr;

    logic [ROW_W-1:0]    n_row;
    logic [COL_W-1:0]    n_col;
    logic [WINDOW_W-1:0] n_window;

    assign rows_eff = clamp_dim(r_rows_cfg, DIM_W'(MAX_ROWS));
    assign cols_eff = clamp_dim(r_cols_cfg, DIM_W'(MAX_COLS));
    assign col_last = DIM_W'(r_col) == cols_eff - DIM_W'(1);
    assign row_last = DIM_W'(r_row) == rows_eff - DIM_W'(1);

    // one read port: the current column, or the flush sweep
    always_comb begin
        if (r_fl_active) begin
            rd_idx = r_fl_primed ? r_fl_k + COL_W'(1) : '0;
        end else begin
            rd_idx = r_col;
        end
    end
    assign rd_above = r_line_above[rd_idx];
    assign rd_two   = r_line_two[rd_idx];

    assign top    = (r_row >= ROW_W'(2)) ? rd_two : ST_EMPTY;
    assign mid    = (r_row != '0) ? rd_above : ST_EMPTY;
    assign newcol = {r_in_cell, mid, top};
    assign prev   = (r_col == '0) ? '0 : r_window[COLUMN_W-1:0];
    assign oldest = r_window[WINDOW_W-1:COLUMN_W];

    assign has_a    = (r_row != '0) && (r_col != '0);
    assign has_b    = (r_row != '0) && col_last;
    assign do_flush = col_last && row_last;

    always_comb begin
        res_a.state = next_of(oldest, prev, newcol);
        res_a.row   = POS_W'(r_row - ROW_W'(1));
        res_a.col   = POS_W'(r_col - COL_W'(1));
        res_a.last  = !has_b && !do_flush;
        res_b.state = next_of(prev, newcol, '0);
        res_b.row   = POS_W'(r_row - ROW_W'(1));
        res_b.col   = POS_W'(r_col);
        res_b.last  = !do_flush;
    end

    // flush of the final row: below it lies nothing
    assign rc_valid = (DIM_W'(r_fl_k) + DIM_W'(1)) < cols_eff;
    assign rc       = rc_valid ? {ST_EMPTY, rd_above, rd_two} : '0;

    always_comb begin
        res_fl.state = next_of(r_fl_left, r_fl_mid, rc);
        res_fl.row   = r_fl_row;
        res_fl.col   = POS_W'(r_fl_k);
        res_fl.last  = !rc_valid;
    end

    assign out_free   = !r_out_valid || i_m_tready;
    assign fl_emit    = r_fl_active && r_fl_primed && !r_b_valid && out_free;
    assign proc       = r_in_valid && !r_b_valid && !r_fl_active && out_free;
    assign o_s_tready = !r_in_valid || proc;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign cfg_wr     = psel && penable && pwrite && pready;

    always_comb begin
        n_row    = r_row;
        n_col    = r_col + COL_W'(1);
        n_window = {prev, newcol};
        if (col_last) begin
            n_col = '0;
            if (row_last) begin
                n_row    = '0;
                n_window = '0;
            end else begin
                n_row = r_row + ROW_W'(1);
            end
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= DIM_RESET;
            r_cols_cfg <= DIM_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_COLS) begin
                r_cols_cfg <= pwdata[CFG_W-1:0];
            end else begin
                r_rows_cfg <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ROWS) ? APB_W'(r_rows_cfg) : APB_W'(r_cols_cfg);

    // frame position and window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_window <= '0;
        end else if (cfg_wr) begin
            r_row    <= '0;
            r_col    <= '0;
            r_window <= '0;
        end else if (proc) begin
            r_row    <= n_row;
            r_col    <= n_col;
            r_window <= n_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_line_two[r_col]   <= r_line_above[r_col];
            r_line_above[r_col] <= r_in_cell;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_cell <= i_s_tdata[CELL_W-1:0];
        end
    end

    // output register and pending second word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_b_valid   <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_b_valid || fl_emit || (proc && (has_a || has_b));
            end
            if (out_free && r_b_valid) begin
                r_b_valid <= 1'b0;
            end else if (proc && has_a && has_b) begin
                r_b_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_b_valid) begin
                r_out <= r_b;
            end else if (fl_emit) begin
                r_out <= res_fl;
            end else if (has_a) begin
                r_out <= res_a;
            end else begin
                r_out <= res_b;
            end
        end
        if (proc && has_a && has_b) begin
            r_b <= res_b;
        end
    end

    // final row sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fl_active <= 1'b0;
            r_fl_primed <= 1'b0;
        end else if (proc && do_flush) begin
            r_fl_active <= 1'b1;
            r_fl_primed <= 1'b0;
        end else if (r_fl_active && !r_fl_primed) begin
            r_fl_primed <= 1'b1;
        end else if (fl_emit && !rc_valid) begin
            r_fl_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && do_flush) begin
            r_fl_k    <= '0;
            r_fl_left <= '0;
            r_fl_row  <= POS_W'(r_row);
        end else if (r_fl_active && !r_fl_primed) begin
            r_fl_mid <= {ST_EMPTY, rd_above, rd_two};
        end else if (fl_emit) begin
            r_fl_left <= r_fl_mid;
            r_fl_mid  <= rc;
            r_fl_k    <= r_fl_k + COL_W'(1);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_DATA_W'({r_out.col, r_out.row, r_out.state});
    assign o_m_tlast  = r_out.last;

endmodule

### src/wwgs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwgs_checker
// Port-level checks for the wireworld generation step.
// ----------------------------------------------------------------------------
module wwgs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tlast
);

    logic out_hs;
    assign out_hs = o_m_tvalid && i_m_tready;

    // a stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output word changed under stall");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // words of one run follow without a gap
    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_hs && !o_m_tlast |=> o_m_tvalid)
        else $error("gap inside a run of result words");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[15:12] == 4'd0)
        else $error("padding bits set on output word");

endmodule

bind wireworld_generation_step wwgs_checker u_wwgs_checker (.*);
